// File: rtl/sfs_pkg.sv
// Schedule frame selector: shared types, codes and constants.
// Used by every module under rtl/; depends on nothing.
package sfs_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  localparam int KEY_W     = 24;
  localparam int AZ_W      = 16;
  localparam int IMG_W     = 8;
  localparam int FRAME_W   = 9;
  localparam int NEXT_W    = 19;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;

  // request opcodes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_CLOCK = 2'd1;
  localparam logic [1:0] OP_SUN   = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SOLAR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DARK  = 2'd2;

  // Q.16 day fractions, 25 bits so sums and clamps never overflow
  localparam logic signed [KEY_W:0] QUARTER_Q16       = 25'sd16384;
  localparam logic signed [KEY_W:0] THREE_QUARTER_Q16 = 25'sd49152;
  localparam logic signed [KEY_W:0] FIVE_QUARTER_Q16  = 25'sd81920;
  localparam logic signed [KEY_W:0] ONE_Q16           = 25'sd65536;
  localparam logic signed [KEY_W:0] NEXT_LOW          = -25'sd65536;
  localparam logic signed [KEY_W:0] NEXT_HIGH         = 25'sd131072;

  // 180.0 degrees in Q9.7
  localparam logic [AZ_W-1:0] AZ_HALF_Q7 = 16'd23040;

  localparam logic signed [FRAME_W-1:0] FRAME_NONE = -9'sd1;

  typedef struct packed {
    logic signed [KEY_W-1:0] tval;
    logic [IMG_W-1:0]        image;
    logic                    east;
  } entry_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
  } ram_req_t;

  typedef struct packed {
    logic                       solar;
    logic signed [FRAME_W-1:0]  light;
    logic signed [FRAME_W-1:0]  dark;
  } cfg_t;

endpackage

// File: rtl/sfs_entry_ram.sv
// Schedule entry store: one write port, one read port, registered read data.
// Depends on sfs_pkg.
module sfs_entry_ram (
  input  logic              clk,
  input  sfs_pkg::ram_req_t req,
  output sfs_pkg::entry_t   rd_data
);

  sfs_pkg::entry_t mem [sfs_pkg::MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

// File: rtl/sfs_seq.sv
// Request sequencer: entry count, table scan over the entry RAM, result register.
// Depends on sfs_pkg; drives the port of sfs_entry_ram.
module sfs_seq (
  input  logic                                 clk,
  input  logic                                 rst,
  input  sfs_pkg::cfg_t                        cfg,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           op,
  input  logic signed [sfs_pkg::KEY_W-1:0]     key_time,
  input  logic [sfs_pkg::AZ_W-1:0]             sun_azimuth,
  input  logic [sfs_pkg::IMG_W-1:0]            image_number,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [sfs_pkg::FRAME_W-1:0]   frame,
  output logic signed [sfs_pkg::NEXT_W-1:0]    next_change,
  output logic                                 table_full,
  output sfs_pkg::ram_req_t                    ram_req,
  input  sfs_pkg::entry_t                      ram_rd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]                        state;
  logic [sfs_pkg::CNT_W-1:0]         count;
  logic [sfs_pkg::CNT_W-1:0]         issue;
  logic                              rd_vld;
  logic                              rd_first;
  logic                              rd_last;

  logic [1:0]                        op_q;
  logic signed [sfs_pkg::KEY_W-1:0]  key_q;
  logic                              rising_q;
  logic                              full_q;

  // scan accumulators
  logic                              hit;
  logic                              le_seen;
  logic signed [sfs_pkg::KEY_W-1:0]  hit_time;
  logic [sfs_pkg::IMG_W-1:0]         chosen;
  logic signed [sfs_pkg::KEY_W-1:0]  time0;
  logic [sfs_pkg::IMG_W-1:0]         img0;
  logic [sfs_pkg::IMG_W-1:0]         img_last;
  logic                              all_found;
  logic [sfs_pkg::KEY_W:0]           all_score;
  logic [sfs_pkg::IMG_W-1:0]         all_img;
  logic                              match_found;
  logic [sfs_pkg::KEY_W:0]           match_score;
  logic [sfs_pkg::IMG_W-1:0]         match_img;

  logic                              accept;
  logic                              table_at_max;
  logic                              out_free;
  logic signed [sfs_pkg::KEY_W:0]    diff;
  logic [sfs_pkg::KEY_W:0]           adiff;

  logic signed [sfs_pkg::FRAME_W-1:0] fin_frame;
  logic signed [sfs_pkg::NEXT_W-1:0]  fin_next;
  logic signed [sfs_pkg::FRAME_W-1:0] wanted;
  logic signed [sfs_pkg::KEY_W:0]     key_ext;
  logic signed [sfs_pkg::KEY_W:0]     cand;
  logic signed [sfs_pkg::KEY_W:0]     clamped;
  logic                               day;

  assign in_stall     = (state != S_IDLE);
  assign accept       = in_valid && (state == S_IDLE);
  assign table_at_max = (count == sfs_pkg::CNT_W'(sfs_pkg::MAX_ENTRIES));
  assign out_free     = !out_valid || !out_stall;

  always_comb begin
    ram_req               = '0;
    ram_req.rd_en         = (state == S_SCAN) && (issue < count);
    ram_req.rd_addr       = issue[sfs_pkg::IDX_W-1:0];
    ram_req.wr_en         = accept && (op == sfs_pkg::OP_LOAD) && !table_at_max;
    ram_req.wr_addr       = count[sfs_pkg::IDX_W-1:0];
    ram_req.wr_data.tval  = key_time;
    ram_req.wr_data.image = image_number;
    ram_req.wr_data.east  = (sun_azimuth < sfs_pkg::AZ_HALF_Q7);
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      issue     <= '0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_vld <= ram_req.rd_en;
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            issue <= '0;
            if (op == sfs_pkg::OP_LOAD && !table_at_max) begin
              count <= count + 1'b1;
            end
            if (op == sfs_pkg::OP_CLEAR) begin
              count <= '0;
            end
            if ((op == sfs_pkg::OP_CLOCK || op == sfs_pkg::OP_SUN) && count != '0) begin
              state <= S_SCAN;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_SCAN: begin
          if (ram_req.rd_en) begin
            issue <= issue + 1'b1;
          end
          if (rd_vld && rd_last) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // request capture and output payload
  always_ff @(posedge clk) begin
    rd_first <= (issue == '0);
    rd_last  <= (issue == count - 1'b1);
    if (accept) begin
      op_q     <= op;
      key_q    <= key_time;
      rising_q <= (sun_azimuth < sfs_pkg::AZ_HALF_Q7);
      full_q   <= (op == sfs_pkg::OP_LOAD) && table_at_max;
    end
    if (state == S_DONE && out_free) begin
      frame       <= fin_frame;
      next_change <= fin_next;
      table_full  <= full_q;
    end
  end

  assign diff  = {ram_rd.tval[sfs_pkg::KEY_W-1], ram_rd.tval} -
                 {key_q[sfs_pkg::KEY_W-1], key_q};
  assign adiff = diff[sfs_pkg::KEY_W] ? $unsigned(-diff) : $unsigned(diff);

  // scan accumulators, cleared per request
  always_ff @(posedge clk) begin
    if (accept) begin
      hit         <= 1'b0;
      le_seen     <= 1'b0;
      all_found   <= 1'b0;
      match_found <= 1'b0;
    end else if (rd_vld) begin
      if (rd_first) begin
        time0 <= ram_rd.tval;
        img0  <= ram_rd.image;
      end
      img_last <= ram_rd.image;
      if (!hit) begin
        if (ram_rd.tval <= key_q) begin
          le_seen <= 1'b1;
          chosen  <= ram_rd.image;
        end else begin
          hit      <= 1'b1;
          hit_time <= ram_rd.tval;
        end
      end
      // strict less-than keeps the earliest entry on ties
      if (!all_found || adiff < all_score) begin
        all_found <= 1'b1;
        all_score <= adiff;
        all_img   <= ram_rd.image;
      end
      if (ram_rd.east == rising_q && (!match_found || adiff < match_score)) begin
        match_found <= 1'b1;
        match_score <= adiff;
        match_img   <= ram_rd.image;
      end
    end
  end

  // result of the finished request
  always_comb begin
    key_ext = {key_q[sfs_pkg::KEY_W-1], key_q};
    day     = (key_ext >= sfs_pkg::QUARTER_Q16) && (key_ext < sfs_pkg::THREE_QUARTER_Q16);
    wanted  = day ? cfg.light : cfg.dark;
    cand    = hit ? {hit_time[sfs_pkg::KEY_W-1], hit_time}
                  : sfs_pkg::ONE_Q16 + {time0[sfs_pkg::KEY_W-1], time0};
    if (cand < sfs_pkg::NEXT_LOW) begin
      clamped = sfs_pkg::NEXT_LOW;
    end else if (cand > sfs_pkg::NEXT_HIGH) begin
      clamped = sfs_pkg::NEXT_HIGH;
    end else begin
      clamped = cand;
    end
    fin_frame = sfs_pkg::FRAME_NONE;
    fin_next  = '0;
    case (op_q)
      sfs_pkg::OP_CLOCK: begin
        if (cfg.solar || count == '0) begin
          if (!wanted[sfs_pkg::FRAME_W-1]) begin
            fin_frame = wanted;
          end else if (count != '0) begin
            fin_frame = {1'b0, img0};
          end
          if (count == '0) begin
            fin_next = sfs_pkg::NEXT_LOW[sfs_pkg::NEXT_W-1:0];
          end else if (key_ext < sfs_pkg::QUARTER_Q16) begin
            fin_next = sfs_pkg::QUARTER_Q16[sfs_pkg::NEXT_W-1:0];
          end else if (key_ext < sfs_pkg::THREE_QUARTER_Q16) begin
            fin_next = sfs_pkg::THREE_QUARTER_Q16[sfs_pkg::NEXT_W-1:0];
          end else begin
            fin_next = sfs_pkg::FIVE_QUARTER_Q16[sfs_pkg::NEXT_W-1:0];
          end
        end else begin
          fin_frame = le_seen ? {1'b0, chosen} : {1'b0, img_last};
          fin_next  = clamped[sfs_pkg::NEXT_W-1:0];
        end
      end
      sfs_pkg::OP_SUN: begin
        if (cfg.solar && count != '0) begin
          fin_frame = match_found ? {1'b0, match_img} : {1'b0, all_img};
        end
      end
      default: begin
        fin_frame = sfs_pkg::FRAME_NONE;
      end
    endcase
  end

endmodule

// File: rtl/schedule_frame_selector.sv
// Schedule frame selector top level: configuration registers, entry RAM, sequencer.
// Depends on sfs_pkg, sfs_entry_ram and sfs_seq.
//
//  channel   direction  handshake            payload
//  ------    ---------  -------------------  ------------------------------------------
//  request   in         in_valid / in_stall  op, key_time, sun_azimuth, image_number
//  result    out        out_valid/out_stall  frame, next_change, table_full
//  config    in         cfg_we               cfg_index, cfg_data
//
// Loads and clears go straight to the result state without a scan.  Clock and
// sun queries walk the entry RAM through its single read port, one entry a
// cycle; an empty table skips the scan.  Reset is synchronous and empties the
// table; the RAM itself is never cleared since only entries below the count are
// read.  One request is in flight at a time; a finished result sits in the output
// register while the next request is taken.
module schedule_frame_selector (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [sfs_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [sfs_pkg::CFG_W-1:0]              cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [1:0]                             op,
  input  logic signed [sfs_pkg::KEY_W-1:0]       key_time,
  input  logic [sfs_pkg::AZ_W-1:0]               sun_azimuth,
  input  logic [sfs_pkg::IMG_W-1:0]              image_number,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [sfs_pkg::FRAME_W-1:0]     frame,
  output logic signed [sfs_pkg::NEXT_W-1:0]      next_change,
  output logic                                   table_full
);

  sfs_pkg::cfg_t     cfg;
  sfs_pkg::ram_req_t ram_req;
  sfs_pkg::entry_t   ram_rd;

  // configuration registers; an unknown index is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.solar <= 1'b0;
      cfg.light <= sfs_pkg::FRAME_NONE;
      cfg.dark  <= sfs_pkg::FRAME_NONE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sfs_pkg::REG_SOLAR: cfg.solar <= cfg_data[0];
        sfs_pkg::REG_LIGHT: cfg.light <= $signed(cfg_data);
        sfs_pkg::REG_DARK:  cfg.dark  <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  sfs_entry_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rd)
  );

  sfs_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .key_time     (key_time),
    .sun_azimuth  (sun_azimuth),
    .image_number (image_number),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frame        (frame),
    .next_change  (next_change),
    .table_full   (table_full),
    .ram_req      (ram_req),
    .ram_rd       (ram_rd)
  );

endmodule
